>>> hdl/clla_pkg.sv
// canopy layer light absorption: shared types, constants and codes
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps
package clla_pkg;

	localparam int MAX_LAYERS  = 64;
	localparam int MAX_COHORTS = 16;
	localparam int LAYER_W     = $clog2(MAX_LAYERS);
	localparam int COHORT_W    = $clog2(MAX_COHORTS);
	localparam int ADDR_W      = LAYER_W + COHORT_W;
	localparam int NLAYER_W    = 7;
	localparam int NCOHORT_W   = 5;
	localparam int CFG_DATA_W  = 7;
	localparam int S_W         = 37;
	localparam int DIV_N_W     = 64;
	localparam int DIV_CNT_W   = $clog2(DIV_N_W);
	localparam int EXP_N_MAX   = 23;

	localparam logic [1:0] CMD_LOAD_COEF = 2'd0;
	localparam logic [1:0] CMD_LOAD_CELL = 2'd1;
	localparam logic [1:0] CMD_COMPUTE   = 2'd2;

	localparam logic REG_LAYERS  = 1'b0;
	localparam logic REG_COHORTS = 1'b1;

	localparam logic [NLAYER_W-1:0]  LAYERS_MAX  = NLAYER_W'(MAX_LAYERS);
	localparam logic [NCOHORT_W-1:0] COHORTS_MAX = NCOHORT_W'(MAX_COHORTS);

	localparam logic [30:0]    Q30_ONE  = 31'h4000_0000;
	localparam logic [29:0]    LN2_Q30  = 30'd744261118;
	localparam logic [S_W-1:0] SSAT_MAX = S_W'(64'h4000_0000);
	localparam logic [3:0]     TERMS    = 4'd14;
	localparam logic [15:0]    LIGHT_ONE = 16'd32768;

	typedef struct packed {
		logic [LAYER_W-1:0]  layer;
		logic [COHORT_W-1:0] cohort;
		logic [15:0]         live_area;
		logic [15:0]         dead_area;
		logic [15:0]         coefficient;
	} in_beat_t;

	typedef enum logic [4:0] {
		DP_NOP, DP_LOAD_COEF, DP_LOAD_CELL, DP_START, DP_READ, DP_SUM_ACC,
		DP_EXP_DIV, DP_EXP_R, DP_TERM_MUL, DP_TERM_DIV, DP_TERM_ADD,
		DP_EXP_DONE, DP_NUM_MUL, DP_SHARE_MUL, DP_SHARE_DIV, DP_SHARE_ACC,
		DP_LIGHT, DP_OUT_LOAD
	} dp_op_t;

	typedef struct packed {
		dp_op_t              op;
		logic [LAYER_W-1:0]  layer;
		logic [COHORT_W-1:0] cohort;
		logic [3:0]          term_idx;
		logic                last;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic sraw_zero;
		logic out_valid;
	} dp_stat_t;

endpackage

>>> hdl/clla_div.sv
// clla_div: restoring divider, one quotient bit per cycle
// depends on clla_pkg
`timescale 1ns / 1ps
module clla_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [clla_pkg::DIV_N_W-1:0] dividend,
	input  logic [clla_pkg::S_W-1:0]     divisor,
	output logic                        done,
	output logic [clla_pkg::DIV_N_W-1:0] quotient
);
	import clla_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_N_W-1:0]   dq_q;
	logic [S_W-1:0]       rem_q;
	logic [S_W-1:0]       div_q;
	logic [S_W:0]         shifted;
	logic [S_W:0]         trial;

	assign shifted = {rem_q, dq_q[DIV_N_W-1]};
	assign trial   = shifted - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_N_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			if (!trial[S_W]) begin
				rem_q <= trial[S_W-1:0];
			end else begin
				rem_q <= shifted[S_W-1:0];
			end
			dq_q <= {dq_q[DIV_N_W-2:0], ~trial[S_W]};
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider restarted while busy");

endmodule

>>> hdl/clla_dp.sv
// clla_dp: stores, extinction sum, exp series, shares, accumulators, output beat
// depends on clla_pkg and clla_div
`timescale 1ns / 1ps
module clla_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  clla_pkg::in_beat_t  in_beat,
	input  clla_pkg::dp_cmd_t   cmd,
	output clla_pkg::dp_stat_t  stat,
	input  logic                m_tready,
	output logic [3:0]          out_cohort,
	output logic [15:0]         out_fraction,
	output logic                out_last
);
	import clla_pkg::*;

	logic [15:0] coef_mem [MAX_COHORTS];
	logic [15:0] live_mem [MAX_LAYERS*MAX_COHORTS];
	logic [15:0] dead_mem [MAX_LAYERS*MAX_COHORTS];
	logic [31:0] acc_q [MAX_COHORTS];

	logic [15:0]        coef_rd_q, live_rd_q, dead_rd_q;
	logic [S_W-1:0]     sraw_q;
	logic [34:0]        x_q;
	logic [4:0]         n_q;
	logic [29:0]        r_q;
	logic [30:0]        term_q, tprod_q, e_q, f30_q;
	logic [33:0]        pos_q, neg_q;
	logic [31:0]        num_q;
	logic [62:0]        sprod_q;
	logic [15:0]        rl_q;
	logic               out_valid_q;
	logic [3:0]         out_cohort_q;
	logic [15:0]        out_frac_q;
	logic               out_last_q;

	logic [ADDR_W-1:0]  wr_addr, rd_addr;
	logic [16:0]        area_sum;
	logic [32:0]        kprod;
	logic [30:0]        ssat;
	logic [34:0]        x_next;
	logic [4:0]         n_next;
	logic [34:0]        nln2, r_full;
	logic [61:0]        tmul;
	logic [33:0]        e_diff;
	logic [30:0]        e_cl;
	logic [31:0]        num_next;
	logic [62:0]        sprod_next;
	logic [46:0]        sacc_p, lprod;
	logic [32:0]        osum;
	logic [17:0]        ofr;
	logic               div_start, div_done;
	logic [DIV_N_W-1:0] div_dividend, quo;
	logic [S_W-1:0]     div_divisor;

	assign wr_addr    = {in_beat.layer, in_beat.cohort};
	assign rd_addr    = {cmd.layer, cmd.cohort};
	assign area_sum   = {1'b0, live_rd_q} + {1'b0, dead_rd_q};
	assign kprod      = 33'(coef_rd_q) * 33'(area_sum);
	assign ssat       = (sraw_q > SSAT_MAX) ? SSAT_MAX[30:0] : sraw_q[30:0];
	assign x_next     = {ssat, 4'b0};
	assign nln2       = 35'(n_q) * 35'(LN2_Q30);
	assign r_full     = x_q - nln2;
	assign tmul       = 62'(term_q) * 62'(r_q);
	assign e_diff     = (pos_q > neg_q) ? pos_q - neg_q : '0;
	assign e_cl       = (e_diff > 34'(Q30_ONE)) ? Q30_ONE : e_diff[30:0];
	assign num_next   = 32'(coef_rd_q) * 32'(live_rd_q);
	assign sprod_next = 63'(f30_q) * 63'(num_q);
	assign sacc_p     = 47'(quo[30:0]) * 47'(rl_q);
	assign lprod      = 47'(rl_q) * 47'(e_q) + (47'd1 << 29);
	assign osum       = {1'b0, acc_q[cmd.cohort]} + 33'd16384;
	assign ofr        = osum[32:15];

	// whole multiples of ln2 in x, by compare against fixed thresholds
	always_comb begin
		n_next = '0;
		for (int k = 1; k <= EXP_N_MAX; k++) begin
			if (x_next >= 35'(k) * 35'(LN2_Q30)) begin
				n_next = 5'(k);
			end
		end
	end

	always_comb begin
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		case (cmd.op)
			DP_TERM_DIV: begin
				div_start    = 1'b1;
				div_dividend = DIV_N_W'(tprod_q);
				div_divisor  = S_W'(cmd.term_idx);
			end
			DP_SHARE_DIV: begin
				div_start    = 1'b1;
				div_dividend = DIV_N_W'(sprod_q);
				div_divisor  = sraw_q;
			end
			default: ;
		endcase
	end

	clla_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (quo)
	);

	// stores
	always_ff @(posedge clk) begin
		if (cmd.op == DP_LOAD_COEF) begin
			coef_mem[in_beat.cohort] <= in_beat.coefficient;
		end
		if (cmd.op == DP_READ) begin
			coef_rd_q <= coef_mem[cmd.cohort];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == DP_LOAD_CELL) begin
			live_mem[wr_addr] <= in_beat.live_area;
			dead_mem[wr_addr] <= in_beat.dead_area;
		end
		if (cmd.op == DP_READ) begin
			live_rd_q <= live_mem[rd_addr];
			dead_rd_q <= dead_mem[rd_addr];
		end
	end

	// arithmetic
	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_START: begin
				sraw_q <= '0;
				rl_q   <= LIGHT_ONE;
				for (int i = 0; i < MAX_COHORTS; i++) begin
					acc_q[i] <= '0;
				end
			end
			DP_SUM_ACC:  sraw_q <= sraw_q + S_W'(kprod);
			DP_EXP_DIV: begin
				x_q <= x_next;
				n_q <= n_next;
			end
			DP_EXP_R: begin
				r_q    <= r_full[29:0];
				term_q <= Q30_ONE;
				pos_q  <= 34'(Q30_ONE);
				neg_q  <= '0;
			end
			DP_TERM_MUL: tprod_q <= tmul[60:30];
			DP_TERM_ADD: begin
				term_q <= quo[30:0];
				if (cmd.term_idx[0]) begin
					neg_q <= neg_q + 34'(quo[30:0]);
				end else begin
					pos_q <= pos_q + 34'(quo[30:0]);
				end
			end
			DP_EXP_DONE: begin
				e_q   <= e_cl >> n_q;
				f30_q <= Q30_ONE - (e_cl >> n_q);
			end
			DP_NUM_MUL:   num_q <= num_next;
			DP_SHARE_MUL: sprod_q <= sprod_next;
			DP_SHARE_ACC: acc_q[cmd.cohort] <= acc_q[cmd.cohort] + sacc_p[46:15];
			DP_LIGHT: begin
				rl_q   <= lprod[45:30];
				sraw_q <= '0;
			end
			DP_OUT_LOAD: begin
				out_cohort_q <= cmd.cohort;
				out_frac_q   <= (ofr > 18'd32768) ? LIGHT_ONE : ofr[15:0];
				out_last_q   <= cmd.last;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == DP_OUT_LOAD) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.div_done  = div_done;
	assign stat.sraw_zero = (sraw_q == '0);
	assign stat.out_valid = out_valid_q;
	assign out_cohort     = out_cohort_q;
	assign out_fraction   = out_frac_q;
	assign out_last       = out_last_q;

endmodule

>>> hdl/clla_ctrl.sv
// clla_ctrl: command decode, config registers, layer/cohort/term sequencing
// depends on clla_pkg
`timescale 1ns / 1ps
module clla_ctrl (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [1:0]                         command,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic                               cfg_index,
	input  logic [clla_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               m_tready,
	input  clla_pkg::dp_stat_t                 stat,
	output clla_pkg::dp_cmd_t                  cmd
);
	import clla_pkg::*;

	typedef enum logic [19:0] {
		S_IDLE      = 20'h00001,
		S_SUM_RD    = 20'h00002,
		S_SUM_ACC   = 20'h00004,
		S_EXP_DIV   = 20'h00008,
		S_EXP_R     = 20'h00020,
		S_TERM_MUL  = 20'h00040,
		S_TERM_DIV  = 20'h00080,
		S_TERM_WAIT = 20'h00100,
		S_TERM_ADD  = 20'h00200,
		S_EXP_DONE  = 20'h00400,
		S_SH_RD     = 20'h00800,
		S_SH_NUM    = 20'h01000,
		S_SH_MUL    = 20'h02000,
		S_SH_DIV    = 20'h04000,
		S_SH_WAIT   = 20'h08000,
		S_SH_ACC    = 20'h10000,
		S_LIGHT     = 20'h20000,
		S_OUT_LOAD  = 20'h40000,
		S_OUT_WAIT  = 20'h80000
	} state_t;

	state_t                state_q, state_d;
	logic [NLAYER_W-1:0]   layers_q;
	logic [NCOHORT_W-1:0]  cohorts_q;
	logic [LAYER_W-1:0]    layer_q, layer_d;
	logic [COHORT_W-1:0]   cohort_q, cohort_d;
	logic [3:0]            term_q, term_d;
	logic                  in_acc, out_acc, last_cohort;
	logic [NLAYER_W-1:0]   cfg_layers;
	logic [NCOHORT_W-1:0]  cfg_cohorts;

	assign s_tready    = (state_q == S_IDLE);
	assign cfg_ready   = (state_q == S_IDLE);
	assign in_acc      = s_tvalid && s_tready;
	assign out_acc     = stat.out_valid && m_tready;
	assign last_cohort = ({1'b0, cohort_q} == cohorts_q - 1'b1);

	always_comb begin
		cfg_layers  = cfg_data[NLAYER_W-1:0];
		cfg_cohorts = cfg_data[NCOHORT_W-1:0];
		if (cfg_layers == '0) begin
			cfg_layers = NLAYER_W'(1);
		end else if (cfg_layers > LAYERS_MAX) begin
			cfg_layers = LAYERS_MAX;
		end
		if (cfg_cohorts == '0) begin
			cfg_cohorts = NCOHORT_W'(1);
		end else if (cfg_cohorts > COHORTS_MAX) begin
			cfg_cohorts = COHORTS_MAX;
		end
	end

	always_comb begin
		state_d      = state_q;
		layer_d      = layer_q;
		cohort_d     = cohort_q;
		term_d       = term_q;
		cmd.op       = DP_NOP;
		cmd.layer    = layer_q;
		cmd.cohort   = cohort_q;
		cmd.term_idx = term_q;
		cmd.last     = last_cohort;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					unique case (command)
						CMD_LOAD_COEF: cmd.op = DP_LOAD_COEF;
						CMD_LOAD_CELL: cmd.op = DP_LOAD_CELL;
						CMD_COMPUTE: begin
							cmd.op   = DP_START;
							layer_d  = LAYER_W'(layers_q - 1'b1);
							cohort_d = '0;
							state_d  = S_SUM_RD;
						end
						default: ;
					endcase
				end
			end
			S_SUM_RD: begin
				cmd.op  = DP_READ;
				state_d = S_SUM_ACC;
			end
			S_SUM_ACC: begin
				cmd.op = DP_SUM_ACC;
				if (last_cohort) begin
					cohort_d = '0;
					state_d  = S_EXP_DIV;
				end else begin
					cohort_d = cohort_q + 1'b1;
					state_d  = S_SUM_RD;
				end
			end
			S_EXP_DIV: begin
				cmd.op  = DP_EXP_DIV;
				state_d = S_EXP_R;
			end
			S_EXP_R: begin
				cmd.op  = DP_EXP_R;
				term_d  = 4'd1;
				state_d = S_TERM_MUL;
			end
			S_TERM_MUL: begin
				cmd.op  = DP_TERM_MUL;
				state_d = S_TERM_DIV;
			end
			S_TERM_DIV: begin
				cmd.op  = DP_TERM_DIV;
				state_d = S_TERM_WAIT;
			end
			S_TERM_WAIT: if (stat.div_done) state_d = S_TERM_ADD;
			S_TERM_ADD: begin
				cmd.op = DP_TERM_ADD;
				if (term_q == TERMS) begin
					state_d = S_EXP_DONE;
				end else begin
					term_d  = term_q + 1'b1;
					state_d = S_TERM_MUL;
				end
			end
			S_EXP_DONE: begin
				cmd.op   = DP_EXP_DONE;
				cohort_d = '0;
				state_d  = stat.sraw_zero ? S_LIGHT : S_SH_RD;
			end
			S_SH_RD: begin
				cmd.op  = DP_READ;
				state_d = S_SH_NUM;
			end
			S_SH_NUM: begin
				cmd.op  = DP_NUM_MUL;
				state_d = S_SH_MUL;
			end
			S_SH_MUL: begin
				cmd.op  = DP_SHARE_MUL;
				state_d = S_SH_DIV;
			end
			S_SH_DIV: begin
				cmd.op  = DP_SHARE_DIV;
				state_d = S_SH_WAIT;
			end
			S_SH_WAIT: if (stat.div_done) state_d = S_SH_ACC;
			S_SH_ACC: begin
				cmd.op = DP_SHARE_ACC;
				if (last_cohort) begin
					state_d = S_LIGHT;
				end else begin
					cohort_d = cohort_q + 1'b1;
					state_d  = S_SH_RD;
				end
			end
			S_LIGHT: begin
				cmd.op   = DP_LIGHT;
				cohort_d = '0;
				if (layer_q == '0) begin
					state_d = S_OUT_LOAD;
				end else begin
					layer_d = layer_q - 1'b1;
					state_d = S_SUM_RD;
				end
			end
			S_OUT_LOAD: begin
				cmd.op  = DP_OUT_LOAD;
				state_d = S_OUT_WAIT;
			end
			S_OUT_WAIT: begin
				if (out_acc) begin
					if (last_cohort) begin
						cohort_d = '0;
						state_d  = S_IDLE;
					end else begin
						cohort_d = cohort_q + 1'b1;
						state_d  = S_OUT_LOAD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			layers_q  <= NLAYER_W'(1);
			cohorts_q <= NCOHORT_W'(1);
			layer_q   <= '0;
			cohort_q  <= '0;
			term_q    <= '0;
		end else begin
			state_q  <= state_d;
			layer_q  <= layer_d;
			cohort_q <= cohort_d;
			term_q   <= term_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_LAYERS:  layers_q  <= cfg_layers;
					REG_COHORTS: cohorts_q <= cfg_cohorts;
					default: ;
				endcase
			end
		end
	end

	a_no_input_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !stat.out_valid) else $error("input taken while result pending");

	a_cohort_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, cohort_q} < cohorts_q) else $error("cohort counter out of range");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT_WAIT && out_acc && last_cohort) |=> state_q == S_IDLE)
		else $error("run did not end after last beat");

endmodule

>>> hdl/canopy_layer_light_absorption_unit.sv
// canopy_layer_light_absorption_unit: top level of the canopy absorption block
// depends on clla_pkg, clla_ctrl, clla_dp (and clla_div below it)
//
//  channel | beats                 | handshake
//  s       | load / compute cmds   | s_tvalid, s_tready
//  m       | one per cohort in use | m_tvalid, m_tready
//  cfg     | register writes       | cfg_valid, cfg_ready
//
// loads are written to the stores as they are accepted; compute walks layers top down,
// per layer the sum over cohorts, the exp series, the shares per cohort (skipped when
// the sum is zero) and the light update; each divide runs on the shared 64-bit divider
// each result beat is loaded once the one before is taken; m_tready low holds the beat
// arst_n clears control state; store contents are undefined until loaded
`timescale 1ns / 1ps
module canopy_layer_light_absorption_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [63:0]                     s_tdata,  // layer, cohort, live_area, dead_area, coefficient
	input  logic [1:0]                      s_tuser,  // command
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [23:0]                     m_tdata,  // result_cohort, absorbed_fraction
	output logic                            m_tlast,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic                            cfg_index,
	input  logic [clla_pkg::CFG_DATA_W-1:0] cfg_data
);
	import clla_pkg::*;

	in_beat_t    in_beat;
	dp_cmd_t     cmd;
	dp_stat_t    stat;
	logic [3:0]  out_cohort;
	logic [15:0] out_fraction;

	assign in_beat.layer       = s_tdata[5:0];
	assign in_beat.cohort      = s_tdata[9:6];
	assign in_beat.live_area   = s_tdata[25:10];
	assign in_beat.dead_area   = s_tdata[41:26];
	assign in_beat.coefficient = s_tdata[57:42];

	clla_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.command   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tready  (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	clla_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_beat      (in_beat),
		.cmd          (cmd),
		.stat         (stat),
		.m_tready     (m_tready),
		.out_cohort   (out_cohort),
		.out_fraction (out_fraction),
		.out_last     (m_tlast)
	);

	assign m_tvalid = stat.out_valid;
	assign m_tdata  = {4'b0, out_fraction, out_cohort};

endmodule

>>> sim/tb_canopy_layer_light_absorption_unit.sv
// testbench for canopy_layer_light_absorption_unit: loads, computes and register writes
// are driven with random gaps on both stream sides; a scoreboard predicts each result
// depends on clla_pkg and the block's RTL
`timescale 1ns / 1ps
module tb_canopy_layer_light_absorption_unit;
	import clla_pkg::*;

	typedef struct packed {
		logic [3:0]  cohort;
		logic [15:0] fraction;
		logic        last;
	} absorbed_t;

	class absorption_scoreboard;
		bit [15:0]   coef_mem [MAX_COHORTS];
		bit [15:0]   live_mem [MAX_LAYERS*MAX_COHORTS];
		bit [15:0]   dead_mem [MAX_LAYERS*MAX_COHORTS];
		int unsigned n_layers = 1;
		int unsigned n_cohorts = 1;
		absorbed_t   pending [$];
		int unsigned errors = 0;
		int unsigned checked = 0;

		function void flag(string msg);
			errors++;
			if (errors <= 10)
				$display("mismatch: %s", msg);
		endfunction

		function int unsigned clamp(int unsigned v, int unsigned hi);
			if (v < 1)
				return 1;
			if (v > hi)
				return hi;
			return v;
		endfunction

		function void set_register(logic idx, logic [CFG_DATA_W-1:0] v);
			if (idx == REG_LAYERS)
				n_layers = clamp(v & 7'h7f, MAX_LAYERS);
			else
				n_cohorts = clamp(v & 7'h1f, 16);
		endfunction

		// exp(-x), x and result in Q.30
		function bit [63:0] exp_neg(bit [63:0] x);
			bit [63:0] n, r, term, pos, neg, e;
			n = x / 64'd744261118;
			r = x - n * 64'd744261118;
			term = 64'd1 << 30;
			pos = term;
			neg = 0;
			for (int i = 1; i <= 14; i++) begin
				term = ((term * r) >> 30) / i;
				if (i % 2)
					neg += term;
				else
					pos += term;
			end
			e = pos > neg ? pos - neg : 0;
			if (e > (64'd1 << 30))
				e = 64'd1 << 30;
			if (n >= 63)
				return 0;
			return e >> n;
		endfunction

		function void note_input(logic [1:0] cmd, in_beat_t b);
			bit [31:0] acc [MAX_COHORTS];
			bit [15:0] light;
			bit [63:0] sraw, ssat, e30, f30, num, share, frac;
			int        base;
			absorbed_t r;
			if (cmd == CMD_LOAD_COEF) begin
				coef_mem[b.cohort] = b.coefficient;
				return;
			end
			if (cmd == CMD_LOAD_CELL) begin
				live_mem[b.layer*MAX_COHORTS + b.cohort] = b.live_area;
				dead_mem[b.layer*MAX_COHORTS + b.cohort] = b.dead_area;
				return;
			end
			if (cmd != CMD_COMPUTE)
				return;
			foreach (acc[c])
				acc[c] = 0;
			light = LIGHT_ONE;
			for (int l = n_layers - 1; l >= 0; l--) begin
				base = l * MAX_COHORTS;
				sraw = 0;
				for (int c = 0; c < n_cohorts; c++)
					sraw += 64'(coef_mem[c]) * (64'(live_mem[base+c]) + 64'(dead_mem[base+c]));
				ssat = sraw > (64'd16 << 26) ? (64'd16 << 26) : sraw;
				e30 = exp_neg(ssat << 4);
				f30 = (64'd1 << 30) - e30;
				if (sraw != 0)
					for (int c = 0; c < n_cohorts; c++) begin
						num = 64'(coef_mem[c]) * 64'(live_mem[base+c]);
						share = (f30 * num) / sraw;
						acc[c] += 32'((share * light) >> 15);
					end
				light = 16'((64'(light) * e30 + (64'd1 << 29)) >> 30);
			end
			for (int c = 0; c < n_cohorts; c++) begin
				frac = (64'(acc[c]) + (64'd1 << 14)) >> 15;
				if (frac > 32768)
					frac = 32768;
				r.cohort = 4'(c);
				r.fraction = 16'(frac);
				r.last = (c + 1 == n_cohorts);
				pending = {pending, r};
			end
		endfunction

		function void check_result(absorbed_t got);
			absorbed_t want;
			checked++;
			if (pending.size() == 0) begin
				flag($sformatf("unexpected beat cohort %0d fraction %0d last %0b",
					got.cohort, got.fraction, got.last));
				return;
			end
			want = pending.pop_front();
			if (got.cohort != want.cohort)
				flag($sformatf("cohort exp %0d got %0d", want.cohort, got.cohort));
			if (got.fraction != want.fraction)
				flag($sformatf("cohort %0d fraction exp %0d got %0d",
					want.cohort, want.fraction, got.fraction));
			if (got.last != want.last)
				flag($sformatf("cohort %0d last exp %0b got %0b",
					want.cohort, want.last, got.last));
		endfunction
	endclass

	logic                  clk = 0;
	logic                  arst_n = 0;
	logic                  s_tvalid = 0;
	logic                  s_tready;
	logic [63:0]           s_tdata = 0;
	logic [1:0]            s_tuser = 0;
	logic                  m_tvalid;
	logic                  m_tready = 0;
	logic [23:0]           m_tdata;
	logic                  m_tlast;
	logic                  cfg_valid = 0;
	logic                  cfg_ready;
	logic                  cfg_index = 0;
	logic [CFG_DATA_W-1:0] cfg_data = 0;

	canopy_layer_light_absorption_unit i_dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	absorption_scoreboard sb = new();
	bit          quiet = 0;
	int unsigned n_items = 0;
	int unsigned n_computes = 0;
	int unsigned stall_left = 0;
	int unsigned idle_cycles = 0;
	bit          coef_done [MAX_COHORTS];
	bit          cell_done [MAX_LAYERS*MAX_COHORTS];

	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				m_tready = 0;
				stall_left--;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				m_tready = 0;
				stall_left = $urandom_range(0, 6);
			end else
				m_tready = 1;
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_result('{m_tdata[3:0], m_tdata[19:4], m_tlast});
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles > 400000) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic logic [15:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hffff;
			2: return 16'($urandom_range(0, 16'h0800));
			3: return 16'($urandom_range(0, 16'h3000));
			default: return 16'($urandom);
		endcase
	endfunction

	// entered and left right after a falling edge
	task automatic send_beat(logic [1:0] cmd, in_beat_t b);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid = 0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		s_tvalid = 1;
		s_tuser = cmd;
		s_tdata = {6'd0, b.coefficient, b.dead_area, b.live_area, b.cohort, b.layer};
		do @(posedge clk); while (!s_tready);
		sb.note_input(cmd, b);
		n_items++;
		if (cmd == CMD_LOAD_COEF)
			coef_done[b.cohort] = 1;
		if (cmd == CMD_LOAD_CELL)
			cell_done[b.layer*MAX_COHORTS + b.cohort] = 1;
		if (cmd == CMD_COMPUTE)
			n_computes++;
		@(negedge clk);
		s_tvalid = 0;
	endtask

	task automatic load_coef(int c, logic [15:0] k);
		send_beat(CMD_LOAD_COEF, '{6'($urandom), 4'(c), 16'($urandom), 16'($urandom), k});
	endtask

	task automatic load_cell(int l, int c, logic [15:0] lv, logic [15:0] dd);
		send_beat(CMD_LOAD_CELL, '{6'(l), 4'(c), lv, dd, 16'($urandom)});
	endtask

	task automatic compute();
		send_beat(CMD_COMPUTE, in_beat_t'({$urandom, $urandom}));
	endtask

	task automatic drain();
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [CFG_DATA_W-1:0] v);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		sb.set_register(idx, v);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	// every cell and coefficient the next compute reads must be loaded
	task automatic fill_missing();
		for (int c = 0; c < sb.n_cohorts; c++)
			if (!coef_done[c])
				load_coef(c, pick_value());
		for (int l = 0; l < sb.n_layers; l++)
			for (int c = 0; c < sb.n_cohorts; c++)
				if (!cell_done[l*MAX_COHORTS + c])
					load_cell(l, c, pick_value(), pick_value());
	endtask

	task automatic random_phase(logic [CFG_DATA_W-1:0] nl, logic [CFG_DATA_W-1:0] nc, int count);
		drain();
		write_reg(REG_LAYERS, nl);
		write_reg(REG_COHORTS, nc);
		fill_missing();
		repeat (count) begin
			case ($urandom_range(0, 9))
				0, 1, 2: load_cell($urandom_range(0, sb.n_layers - 1),
					$urandom_range(0, sb.n_cohorts - 1), pick_value(), pick_value());
				3: load_cell($urandom_range(0, 63), $urandom_range(0, 15),
					pick_value(), pick_value());
				4, 5: load_coef($urandom_range(0, 15), pick_value());
				6: send_beat(2'd3, in_beat_t'({$urandom, $urandom}));
				default: compute();
			endcase
		end
		compute();
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// defaults: one layer, one cohort
		load_coef(0, 16'hffff);
		load_cell(0, 0, 16'hffff, 16'hffff);
		compute();
		load_cell(0, 0, 16'h0000, 16'h0000);
		compute();
		load_cell(0, 0, 16'h1000, 16'h0800);
		load_coef(0, 16'h0000);
		compute();
		send_beat(2'd3, in_beat_t'({$urandom, $urandom}));
		load_coef(0, 16'h2000);
		compute();
		load_cell(0, 0, 16'h0000, 16'h4000);
		compute();

		// extremes of both registers, out-of-range writes saturate
		drain();
		write_reg(REG_LAYERS, 7'h7f);
		write_reg(REG_COHORTS, 7'd0);
		fill_missing();
		load_cell(63, 0, 16'h0400, 16'h0200);
		compute();
		drain();
		write_reg(REG_LAYERS, 7'd0);
		write_reg(REG_COHORTS, 7'h1f);
		fill_missing();
		load_cell(0, 15, 16'hffff, 16'h0000);
		compute();
		random_phase(7'd2, 7'd16, 3);

		while (n_items < 170) begin
			if (n_items > 140)
				quiet = 1;
			random_phase(7'($urandom_range(1, 6)), 7'($urandom_range(1, 16)),
				$urandom_range(6, 16));
		end

		drain();
		repeat (50) @(negedge clk);
		while (sb.pending.size() != 0) begin
			absorbed_t w;
			w = sb.pending.pop_front();
			sb.flag($sformatf("cohort %0d fraction %0d never came", w.cohort, w.fraction));
		end
		$display("covered %0d input beats, %0d computes, %0d result beats checked",
			n_items, n_computes, sb.checked);
		$display("register extremes, saturation, zero extinction sum, ignored command; %0d errors",
			sb.errors);
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
